>>> rtl/pcicap_pkg.sv
// Shared constants, codes and item types for the PCI configuration access port.
package pcicap_pkg;

  localparam int NUM_DEVICES   = 8;
  localparam int CONFIG_DWORDS = 16;
  localparam int BAR_COUNT     = 6;
  localparam int HEADER_DWORDS = 16;

  localparam int CFG_DEPTH = NUM_DEVICES * CONFIG_DWORDS;
  localparam int CFG_AW    = $clog2(CFG_DEPTH);
  localparam int BAR_DEPTH = NUM_DEVICES * BAR_COUNT;
  localparam int BAR_AW    = $clog2(BAR_DEPTH);

  localparam logic [1:0] OP_IO_READ  = 2'd0;
  localparam logic [1:0] OP_IO_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD_CFG = 2'd2;
  localparam logic [1:0] OP_LOAD_BAR = 2'd3;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_DWORD = 2'd2;
  localparam logic [1:0] SIZE_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNHANDLED = 2'd1;
  localparam logic [1:0] ST_NO_ENABLE = 2'd2;

  localparam logic [2:0] PORT_ADDR = 3'd0;
  localparam logic [2:0] PORT_DATA = 3'd4;

  localparam logic [31:0] MATCH_MASK = 32'h7FFF_FF00;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  // Register numbers (dword index, address bits 7:2)
  localparam logic [5:0] REG_COMMAND = 6'd1;
  localparam logic [5:0] REG_BIST    = 6'd3;
  localparam logic [5:0] REG_BAR_LO  = 6'd4;
  localparam logic [5:0] REG_BAR_END = 6'd10;
  localparam logic [5:0] REG_HDR_END = 6'(HEADER_DWORDS);

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  port_offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic [2:0]  load_device;
    logic [3:0]  load_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic              cfg_we_lo;
    logic              cfg_we_hi;
    logic [CFG_AW-1:0] cfg_waddr;
    logic [31:0]       cfg_wdata;
    logic              bar_we;
    logic [BAR_AW-1:0] bar_waddr;
    logic [31:0]       bar_wdata;
  } store_wr_t;

  typedef struct packed {
    logic              rd_en;
    logic [CFG_AW-1:0] cfg_raddr;
    logic [BAR_AW-1:0] bar_raddr;
  } store_rd_t;

endpackage

>>> rtl/pcicap_store.sv
// Configuration dword store and BAR size store with registered reads.
module pcicap_store (
  input  logic                  clk,
  input  pcicap_pkg::store_wr_t wr,
  input  pcicap_pkg::store_rd_t rd,
  output logic [31:0]           cfg_rdata,
  output logic [31:0]           bar_rdata
);

  logic [31:0] cfg_mem_r [pcicap_pkg::CFG_DEPTH];
  logic [31:0] bar_mem_r [pcicap_pkg::BAR_DEPTH];
  logic [31:0] cfg_rdata_r;
  logic [31:0] bar_rdata_r;

  always_ff @(posedge clk) begin
    if (wr.cfg_we_lo) begin
      cfg_mem_r[wr.cfg_waddr][15:0] <= wr.cfg_wdata[15:0];
    end
    if (wr.cfg_we_hi) begin
      cfg_mem_r[wr.cfg_waddr][31:16] <= wr.cfg_wdata[31:16];
    end
    if (wr.bar_we) begin
      bar_mem_r[wr.bar_waddr] <= wr.bar_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.rd_en) begin
      cfg_rdata_r <= cfg_mem_r[rd.cfg_raddr];
      bar_rdata_r <= bar_mem_r[rd.bar_raddr];
    end
  end

  assign cfg_rdata = cfg_rdata_r;
  assign bar_rdata = bar_rdata_r;

endmodule

>>> rtl/pci_config_access_port_top.sv
// PCI configuration mechanism 1 bridge: address register, config and BAR size stores.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries io reads and writes
//   of ports 0xCF8..0xCFF and load items that fill the config dword store and
//   the BAR size store. Each item yields exactly one result item on the output
//   channel (out_valid / out_stall / out_item) with read data and status.
//   cfg_device_count is written over cfg_valid / cfg_ready; cfg_ready is always
//   high. Write it only while no item is in flight.
// Timing:
//   The store read and the address decode are registered at the accepting edge;
//   the read result is then formed and registered once the output is free.
//   One item per cycle sustained while the output does not stall; each store
//   answers one registered read per cycle, which is all an item needs.
// Reset (rst_n low, synchronous): address register and device count clear to
//   zero and the pipeline empties. Store contents are not cleared; reading an
//   entry that was never loaded returns undefined data.
// Stall: a stalled result holds on the output; the block keeps accepting
//   until its internal stage is also full, then raises in_stall.
module pci_config_access_port_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pcicap_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pcicap_pkg::out_item_t out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_device_count
);

  logic [31:0] addr_r;
  logic [3:0]  dev_count_r;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_is_rd_r;
  logic [2:0]  s1_off_r;
  logic [1:0]  s1_size_r;
  logic [1:0]  s1_status_r;
  logic        s1_present_r;
  logic [5:0]  s1_idx_r;
  logic [31:0] s1_addr_r;

  logic                  out_valid_r, out_valid_nxt;
  pcicap_pkg::out_item_t out_item_r, out_item_nxt;

  logic in_acc;
  logic out_load;

  // Stage 0: decode against the current address register
  logic [4:0]  dev_f;
  logic [5:0]  limit;
  logic        present;
  logic [5:0]  idx;
  logic        is_bar;
  logic        is_rd;
  logic [1:0]  status0;
  logic        addr_we;
  logic [31:0] addr_val;
  pcicap_pkg::store_wr_t wr;
  pcicap_pkg::store_rd_t rd;
  logic [31:0] cfg_rdata;
  logic [31:0] bar_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = s1_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    dev_f   = addr_r[15:11];
    limit   = ({2'b00, dev_count_r} > 6'(pcicap_pkg::NUM_DEVICES)) ?
              6'(pcicap_pkg::NUM_DEVICES) : {2'b00, dev_count_r};
    present = ((addr_r & pcicap_pkg::MATCH_MASK) == {16'd0, dev_f, 11'd0}) &&
              ({1'b0, dev_f} < limit);
    idx     = addr_r[7:2];
    is_bar  = (idx >= pcicap_pkg::REG_BAR_LO) && (idx < pcicap_pkg::REG_BAR_END);
  end

  always_comb begin
    is_rd    = 1'b0;
    status0  = pcicap_pkg::ST_OK;
    addr_we  = 1'b0;
    addr_val = addr_r;
    wr       = '0;
    case (in_item.operation)
      pcicap_pkg::OP_LOAD_CFG: begin
        if (32'(in_item.load_device) < pcicap_pkg::NUM_DEVICES &&
            32'(in_item.load_index) < pcicap_pkg::CONFIG_DWORDS) begin
          wr.cfg_we_lo = 1'b1;
          wr.cfg_we_hi = 1'b1;
          wr.cfg_waddr = pcicap_pkg::CFG_AW'(32'(in_item.load_device) *
                         pcicap_pkg::CONFIG_DWORDS + 32'(in_item.load_index));
          wr.cfg_wdata = in_item.write_data;
        end else begin
          status0 = pcicap_pkg::ST_UNHANDLED;
        end
      end
      pcicap_pkg::OP_LOAD_BAR: begin
        if (32'(in_item.load_device) < pcicap_pkg::NUM_DEVICES &&
            32'(in_item.load_index) < pcicap_pkg::BAR_COUNT) begin
          wr.bar_we    = 1'b1;
          wr.bar_waddr = pcicap_pkg::BAR_AW'(32'(in_item.load_device) *
                         pcicap_pkg::BAR_COUNT + 32'(in_item.load_index));
          wr.bar_wdata = in_item.write_data;
        end else begin
          status0 = pcicap_pkg::ST_UNHANDLED;
        end
      end
      default: begin
        if (in_item.access_size == pcicap_pkg::SIZE_RSVD) begin
          status0 = pcicap_pkg::ST_UNHANDLED;
        end else if (in_item.operation == pcicap_pkg::OP_IO_READ) begin
          is_rd = 1'b1;
        end else if (in_item.port_offset < pcicap_pkg::PORT_DATA) begin
          if (in_item.access_size == pcicap_pkg::SIZE_DWORD &&
              in_item.port_offset == pcicap_pkg::PORT_ADDR) begin
            addr_we  = 1'b1;
            addr_val = {in_item.write_data[31:2], 2'b00};
            if (!in_item.write_data[31]) begin
              status0 = pcicap_pkg::ST_NO_ENABLE;
            end
          end else if (in_item.access_size == pcicap_pkg::SIZE_BYTE) begin
            addr_we = 1'b1;
            addr_val[{in_item.port_offset[1:0], 3'b000} +: 8] = in_item.write_data[7:0];
            addr_val[1:0] = 2'b00;
          end else begin
            status0 = pcicap_pkg::ST_UNHANDLED;
          end
        end else if (in_item.access_size == pcicap_pkg::SIZE_DWORD) begin
          if (in_item.port_offset != pcicap_pkg::PORT_DATA) begin
            status0 = pcicap_pkg::ST_UNHANDLED;
          end else if (present) begin
            if (is_bar) begin
              wr.cfg_we_lo = 1'b1;
              wr.cfg_we_hi = 1'b1;
              wr.cfg_waddr = pcicap_pkg::CFG_AW'(32'(dev_f) *
                             pcicap_pkg::CONFIG_DWORDS + 32'(idx));
              wr.cfg_wdata = in_item.write_data;
            end else begin
              status0 = pcicap_pkg::ST_UNHANDLED;
            end
          end
        end else if (in_item.access_size == pcicap_pkg::SIZE_WORD) begin
          if (in_item.port_offset == pcicap_pkg::PORT_DATA && present &&
              idx == pcicap_pkg::REG_COMMAND) begin
            wr.cfg_we_lo = 1'b1;
            wr.cfg_waddr = pcicap_pkg::CFG_AW'(32'(dev_f) *
                           pcicap_pkg::CONFIG_DWORDS + 32'(pcicap_pkg::REG_COMMAND));
            wr.cfg_wdata = in_item.write_data;
          end else begin
            status0 = pcicap_pkg::ST_UNHANDLED;
          end
        end else begin
          if (present && idx != pcicap_pkg::REG_BIST && !is_bar) begin
            status0 = pcicap_pkg::ST_UNHANDLED;
          end
        end
      end
    endcase
    wr.cfg_we_lo = wr.cfg_we_lo && in_acc;
    wr.cfg_we_hi = wr.cfg_we_hi && in_acc;
    wr.bar_we    = wr.bar_we && in_acc;
  end

  always_comb begin
    rd.rd_en     = in_acc;
    rd.cfg_raddr = pcicap_pkg::CFG_AW'(32'(dev_f) * pcicap_pkg::CONFIG_DWORDS + 32'(idx));
    rd.bar_raddr = pcicap_pkg::BAR_AW'(32'(dev_f) * pcicap_pkg::BAR_COUNT + 32'(idx) -
                   32'(pcicap_pkg::REG_BAR_LO));
  end

  pcicap_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd        (rd),
    .cfg_rdata (cfg_rdata),
    .bar_rdata (bar_rdata)
  );

  // Stage 1: form the read result
  function automatic logic [31:0] narrow(input logic [31:0] v, input logic [1:0] size);
    logic [31:0] r;
    case (size)
      pcicap_pkg::SIZE_BYTE: r = {24'd0, v[7:0]};
      pcicap_pkg::SIZE_WORD: r = {16'd0, v[15:0]};
      default:               r = v;
    endcase
    return r;
  endfunction

  logic [31:0] dword;
  logic        bad;
  logic        s1_is_bar;

  always_comb begin
    s1_is_bar = (s1_idx_r >= pcicap_pkg::REG_BAR_LO) && (s1_idx_r < pcicap_pkg::REG_BAR_END);
    bad       = s1_present_r && (s1_idx_r >= pcicap_pkg::REG_HDR_END);
    if (!s1_present_r || bad) begin
      dword = pcicap_pkg::ALL_ONES;
    end else if (s1_is_bar && cfg_rdata == pcicap_pkg::ALL_ONES) begin
      dword = ~(bar_rdata - 32'd1);
    end else begin
      dword = cfg_rdata;
    end

    out_item_nxt.read_data = '0;
    out_item_nxt.status    = s1_status_r;
    if (s1_is_rd_r) begin
      if (s1_off_r < pcicap_pkg::PORT_DATA) begin
        if (s1_size_r == pcicap_pkg::SIZE_DWORD && s1_off_r == pcicap_pkg::PORT_ADDR) begin
          out_item_nxt.read_data = s1_addr_r;
        end else begin
          out_item_nxt.read_data = narrow(pcicap_pkg::ALL_ONES, s1_size_r);
          out_item_nxt.status    = pcicap_pkg::ST_UNHANDLED;
        end
      end else if (s1_size_r == pcicap_pkg::SIZE_DWORD) begin
        if (s1_off_r == pcicap_pkg::PORT_DATA) begin
          out_item_nxt.read_data = dword;
          out_item_nxt.status    = bad ? pcicap_pkg::ST_UNHANDLED : pcicap_pkg::ST_OK;
        end else begin
          out_item_nxt.read_data = pcicap_pkg::ALL_ONES;
          out_item_nxt.status    = pcicap_pkg::ST_UNHANDLED;
        end
      end else begin
        out_item_nxt.read_data = narrow(dword >> {s1_off_r[1:0], 3'b000}, s1_size_r);
        out_item_nxt.status    = bad ? pcicap_pkg::ST_UNHANDLED : pcicap_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      dev_count_r <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && addr_we) begin
        addr_r <= addr_val;
      end
      if (cfg_valid && cfg_ready) begin
        dev_count_r <= cfg_device_count;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_is_rd_r   <= is_rd;
      s1_off_r     <= in_item.port_offset;
      s1_size_r    <= in_item.access_size;
      s1_status_r  <= status0;
      s1_present_r <= present;
      s1_idx_r     <= idx;
      s1_addr_r    <= addr_r;
    end
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/pcicap_checker.sv
// Port-level checks for the PCI configuration access port, bound to the top level.
module pcicap_port_checks (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input pcicap_pkg::out_item_t out_item
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // A stalled result item stays on the port unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed or dropped");

  // Input is held off only when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result item");

  // A new result appears only after an accepted item has passed through stage 1
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result item without an accepted item two cycles earlier");

  // An accepted item reaches the output when the receiver does not stall
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach the output");

  // Status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status <= pcicap_pkg::ST_NO_ENABLE)
    else $error("illegal status code");

endmodule

bind pci_config_access_port_top pcicap_port_checks u_port_checks (.*);
